>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk_i with rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// Three-wire RTC serial master package
// Operation codes, transaction stages, pin bundle and register indexes.
// ----------------------------------------------------------------------------
package twrtc_pkg;

  typedef enum logic [1:0] {
    OpSingleWrite = 2'd0,
    OpSingleRead  = 2'd1,
    OpBurstWrite  = 2'd2,
    OpBurstRead   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StageClear = 2'd0,
    StageBurst = 2'd1,
    StageSet   = 2'd2
  } stage_e;

  typedef struct packed {
    logic drive;
    logic dout;
    logic sclk;
    logic ce;
  } pins_t;

  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CfgBurstCommand   = 2'd0,
    CfgControlAddress = 2'd1
  } cfg_index_e;

  localparam logic [7:0] BurstCommandReset   = 8'd190;
  localparam logic [7:0] ControlAddressReset = 8'd142;
  localparam logic [7:0] WpClearByte         = 8'h00;
  localparam logic [7:0] WpSetByte           = 8'h80;

endpackage

>>> rtl/three_wire_rtc_serial_master.sv
// Each accepted input transfer yields its registered result transfer in the cycle after it.
// Throughput: one item per cycle while results are taken; the result register frees as it is taken.
// Each tick item advances the serial waveform by one half bit.
// Reset clears all control state and drives all pins low with the line released.
// Configuration defaults after reset are 190 and 142.
// ----------------------------------------------------------------------------
// Three-wire RTC serial master
// Sequences command and data bytes LSB first on chip enable, serial clock and
// a bidirectional data line; burst writes are wrapped in write-protect writes.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master #(
  parameter int unsigned BURST_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [twrtc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [1:0]                      operation_i,
  input  logic [7:0]                      address_i,
  input  logic [63:0]                     write_data_i,
  input  logic                            io_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            chip_enable_o,
  output logic                            serial_clock_o,
  output logic                            data_out_o,
  output logic                            data_drive_o,
  output logic [7:0]                      read_byte_o,
  output logic                            read_valid_o,
  output logic [2:0]                      read_index_o,
  output logic                            busy_res_o,
  output logic                            done_res_o
);
  import twrtc_pkg::*;

  localparam int unsigned ByteW = $clog2(BURST_BYTES + 2);
  localparam logic [ByteW-1:0] BurstLen = ByteW'(BURST_BYTES);
  localparam logic [ByteW-1:0] OneByte  = ByteW'(1);

  logic [7:0]       burst_cmd_q, ctrl_addr_q;
  logic             active_q, active_d;
  op_e              op_q, op_d;
  stage_e           stage_q, stage_d;
  logic             phase_q, phase_d;
  logic [2:0]       bit_q, bit_d;
  logic [ByteW-1:0] byte_q, byte_d, byte_inc, n_data;
  logic [7:0]       shift_q, shift_d, shift_in;
  logic [63:0]      buf_q, buf_d;
  logic [7:0]       addr_q, addr_d;
  pins_t            pins_q, pins_d;
  logic             is_read, reading;
  op_e              start_op;
  stage_e           start_stage, next_stage;
  logic [7:0]       rbyte, next_byte;
  logic             rvalid, done;
  logic [2:0]       rindex;
  logic             in_fire;

  logic             out_valid_q;
  pins_t            out_pins_q;
  logic [7:0]       out_rbyte_q;
  logic             out_rvalid_q, out_busy_q, out_done_q;
  logic [2:0]       out_rindex_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign is_read  = (op_q == OpSingleRead) || (op_q == OpBurstRead);
  assign reading  = is_read && (byte_q != '0);
  assign n_data   = ((op_q == OpBurstRead) || (op_q == OpBurstWrite && stage_q == StageBurst))
                    ? BurstLen : OneByte;
  assign byte_inc = byte_q + OneByte;
  assign shift_in = {io_in_i, shift_q[7:1]};
  assign start_op = op_e'(operation_i);
  assign start_stage = (start_op == OpBurstWrite) ? StageClear : StageBurst;
  assign next_stage  = stage_e'(stage_q + 2'd1);

  always_comb begin
    active_d  = active_q;
    op_d      = op_q;
    stage_d   = stage_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    buf_d     = buf_q;
    addr_d    = addr_q;
    pins_d    = pins_q;
    rbyte     = '0;
    rvalid    = 1'b0;
    rindex    = '0;
    done      = 1'b0;
    next_byte = buf_q[7:0];
    if (kind_i) begin
      if (!active_q) begin
        active_d = 1'b1;
        op_d     = start_op;
        stage_d  = start_stage;
        addr_d   = address_i;
        buf_d    = write_data_i;
        phase_d  = 1'b0;
        bit_d    = '0;
        byte_d   = '0;
        case (start_op)
          OpSingleWrite, OpSingleRead: shift_d = address_i;
          OpBurstRead:                 shift_d = burst_cmd_q + 8'd1;
          default:                     shift_d = ctrl_addr_q;
        endcase
        pins_d = '{drive: 1'b1, dout: 1'b0, sclk: 1'b0, ce: 1'b1};
      end
    end else if (active_q) begin
      if (byte_q <= n_data) begin
        if (!phase_q) begin
          if (reading) begin
            shift_d = shift_in;
            pins_d  = '{drive: 1'b0, dout: 1'b0, sclk: 1'b0, ce: 1'b1};
          end else begin
            shift_d = {1'b0, shift_q[7:1]};
            pins_d  = '{drive: 1'b1, dout: shift_q[0], sclk: 1'b0, ce: 1'b1};
          end
          phase_d = 1'b1;
        end else begin
          pins_d.ce   = 1'b1;
          pins_d.sclk = 1'b1;
          phase_d     = 1'b0;
          if (bit_q == 3'd7) begin
            if (reading) begin
              rbyte  = shift_q;
              rvalid = 1'b1;
              rindex = 3'(byte_q - OneByte);
            end
            bit_d  = '0;
            byte_d = byte_inc;
            case (stage_q)
              StageClear: next_byte = WpClearByte;
              StageSet:   next_byte = WpSetByte;
              default:    next_byte = buf_q[7:0];
            endcase
            if (byte_inc <= n_data) begin
              if (is_read) begin
                shift_d = '0;
              end else begin
                shift_d = next_byte;
                if (stage_q == StageBurst) begin
                  buf_d = {8'h00, buf_q[63:8]};
                end
              end
            end
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
      end else begin
        pins_d = '0;
        if (op_q == OpBurstWrite && stage_q != StageSet) begin
          stage_d = next_stage;
          phase_d = 1'b0;
          bit_d   = '0;
          byte_d  = '0;
          shift_d = (next_stage == StageBurst) ? burst_cmd_q : ctrl_addr_q;
        end else begin
          active_d = 1'b0;
          done     = 1'b1;
        end
      end
    end else begin
      pins_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cmd_q  <= BurstCommandReset;
      ctrl_addr_q  <= ControlAddressReset;
      active_q     <= 1'b0;
      op_q         <= OpSingleWrite;
      stage_q      <= StageClear;
      phase_q      <= 1'b0;
      bit_q        <= '0;
      byte_q       <= '0;
      shift_q      <= '0;
      buf_q        <= '0;
      addr_q       <= '0;
      pins_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgBurstCommand:   burst_cmd_q <= cfg_data_i;
          CfgControlAddress: ctrl_addr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        active_q    <= active_d;
        op_q        <= op_d;
        stage_q     <= stage_d;
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        byte_q      <= byte_d;
        shift_q     <= shift_d;
        buf_q       <= buf_d;
        addr_q      <= addr_d;
        pins_q      <= pins_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_pins_q   <= '0;
      out_rbyte_q  <= '0;
      out_rvalid_q <= 1'b0;
      out_rindex_q <= '0;
      out_busy_q   <= 1'b0;
      out_done_q   <= 1'b0;
    end else if (in_fire) begin
      out_pins_q   <= pins_d;
      out_rbyte_q  <= rbyte;
      out_rvalid_q <= rvalid;
      out_rindex_q <= rindex;
      out_busy_q   <= active_d;
      out_done_q   <= done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_enable_o  = out_pins_q.ce;
  assign serial_clock_o = out_pins_q.sclk;
  assign data_out_o     = out_pins_q.dout;
  assign data_drive_o   = out_pins_q.drive;
  assign read_byte_o    = out_rbyte_q;
  assign read_valid_o   = out_rvalid_q;
  assign read_index_o   = out_rindex_q;
  assign busy_res_o     = out_busy_q;
  assign done_res_o     = out_done_q;

endmodule

>>> rtl/twrtc_checker.sv
// ----------------------------------------------------------------------------
// Three-wire RTC serial master checker
// Port-level properties of the result channel, bound to the serial master module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twrtc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic chip_enable_o,
  input logic serial_clock_o,
  input logic data_drive_o,
  input logic read_valid_o,
  input logic busy_res_o,
  input logic done_res_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_IMPL(a_done_idle, out_valid_o && done_res_o, !busy_res_o && !chip_enable_o)
  `ASSERT_IMPL(a_read_phase, out_valid_o && read_valid_o,
               chip_enable_o && serial_clock_o && !data_drive_o && busy_res_o)
  `ASSERT_IMPL(a_idle_pins, out_valid_o && !busy_res_o,
               !chip_enable_o && !serial_clock_o && !data_drive_o)

endmodule

bind three_wire_rtc_serial_master twrtc_checker u_twrtc_checker (.*);

>>> dv/rtc_master_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC master scoreboard
// Cycle-exact model of the serial sequencer. Every accepted input transfer
// yields one expected result, and each result transfer is compared with it.
// ----------------------------------------------------------------------------
package rtc_master_tb_pkg;
  import twrtc_pkg::*;

  localparam int unsigned BurstBytes  = 8;
  localparam int unsigned ReportLimit = 10;

  typedef enum logic {
    KindTick  = 1'b0,
    KindStart = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    op_e         operation;
    logic [7:0]  address;
    logic [63:0] write_data;
    logic        io_in;
  } rtc_item_t;

  typedef struct packed {
    logic       ce;
    logic       sclk;
    logic       dout;
    logic       drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic [2:0] read_index;
    logic       busy;
    logic       done;
  } rtc_step_t;

  class rtc_waveform_scoreboard;
    logic [7:0]  burst_command;
    logic [7:0]  control_address;
    bit          active;
    op_e         op;
    stage_e      stage;
    bit          high_phase;
    logic [2:0]  bit_cnt;
    int unsigned byte_cnt;
    logic [7:0]  shifter;
    logic [63:0] buffer;
    logic [7:0]  single_address;
    pins_t       pins;
    rtc_step_t   expected_steps[$];
    int unsigned failures;

    function new();
      burst_command   = BurstCommandReset;
      control_address = ControlAddressReset;
      active          = 1'b0;
      op              = OpSingleWrite;
      stage           = StageClear;
      high_phase      = 1'b0;
      bit_cnt         = '0;
      byte_cnt        = 0;
      shifter         = '0;
      buffer          = '0;
      single_address  = '0;
      pins            = '0;
      failures        = 0;
    endfunction

    function void set_register(cfg_index_e index, logic [7:0] value);
      case (index)
        CfgBurstCommand:   burst_command = value;
        CfgControlAddress: control_address = value;
        default: ;
      endcase
    endfunction

    function void open_transaction();
      byte_cnt   = 0;
      bit_cnt    = '0;
      high_phase = 1'b0;
      if (op == OpSingleWrite || op == OpSingleRead) begin
        shifter = single_address;
      end else if (op == OpBurstRead) begin
        shifter = burst_command + 8'd1;
      end else if (stage == StageBurst) begin
        shifter = burst_command;
      end else begin
        shifter = control_address;
      end
    endfunction

    function void predict_step(rtc_item_t item);
      rtc_step_t   step;
      int unsigned n;
      int unsigned k;
      bit          is_read;
      bit          reading;
      logic        bit_out;
      step = '0;
      if (item.kind == KindStart) begin
        if (!active) begin
          active         = 1'b1;
          op             = item.operation;
          single_address = item.address;
          buffer         = item.write_data;
          stage          = (op == OpBurstWrite) ? StageClear : StageBurst;
          open_transaction();
          pins = '{drive: 1'b1, dout: 1'b0, sclk: 1'b0, ce: 1'b1};
        end
      end else if (active) begin
        is_read = (op == OpSingleRead || op == OpBurstRead);
        n = (op == OpBurstRead || (op == OpBurstWrite && stage == StageBurst)) ?
            BurstBytes : 1;
        if (byte_cnt <= n) begin
          reading = is_read && byte_cnt >= 1;
          if (!high_phase) begin
            if (reading) begin
              shifter = {item.io_in, shifter[7:1]};
              pins    = '{drive: 1'b0, dout: 1'b0, sclk: 1'b0, ce: 1'b1};
            end else begin
              bit_out = shifter[0];
              shifter = shifter >> 1;
              pins    = '{drive: 1'b1, dout: bit_out, sclk: 1'b0, ce: 1'b1};
            end
            high_phase = 1'b1;
          end else begin
            pins.ce    = 1'b1;
            pins.sclk  = 1'b1;
            high_phase = 1'b0;
            if (bit_cnt == 3'd7) begin
              if (reading) begin
                step.read_byte  = shifter;
                step.read_valid = 1'b1;
                step.read_index = 3'(byte_cnt - 1);
              end
              bit_cnt = '0;
              byte_cnt++;
              if (byte_cnt <= n) begin
                k = byte_cnt - 1;
                if (is_read) begin
                  shifter = '0;
                end else if (op == OpSingleWrite) begin
                  shifter = buffer[7:0];
                end else if (stage == StageClear) begin
                  shifter = WpClearByte;
                end else if (stage == StageSet) begin
                  shifter = WpSetByte;
                end else if (k >= 8) begin
                  shifter = '0;
                end else begin
                  shifter = 8'(buffer >> (8 * k));
                end
              end
            end else begin
              bit_cnt = bit_cnt + 3'd1;
            end
          end
        end else begin
          pins = '0;
          if (op == OpBurstWrite && stage != StageSet) begin
            stage = (stage == StageClear) ? StageBurst : StageSet;
            open_transaction();
          end else begin
            active    = 1'b0;
            step.done = 1'b1;
          end
        end
      end else begin
        pins = '0;
      end
      step.ce    = pins.ce;
      step.sclk  = pins.sclk;
      step.dout  = pins.dout;
      step.drive = pins.drive;
      step.busy  = active;
      expected_steps.push_back(step);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= ReportLimit) begin
        $display("%s", msg);
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        report($sformatf("Mismatch on %s: expected %0h, actual %0h", name, exp_v, act_v));
      end
    endfunction

    function void check_step(rtc_step_t actual);
      rtc_step_t exp_step;
      if (expected_steps.size() == 0) begin
        report($sformatf("Result transfer with nothing expected: %h", actual));
        return;
      end
      exp_step = expected_steps.pop_front();
      compare_field("chip_enable", exp_step.ce, actual.ce);
      compare_field("serial_clock", exp_step.sclk, actual.sclk);
      compare_field("data_out", exp_step.dout, actual.dout);
      compare_field("data_drive", exp_step.drive, actual.drive);
      compare_field("read_byte", exp_step.read_byte, actual.read_byte);
      compare_field("read_valid", exp_step.read_valid, actual.read_valid);
      compare_field("read_index", exp_step.read_index, actual.read_index);
      compare_field("busy_res", exp_step.busy, actual.busy);
      compare_field("done_res", exp_step.done, actual.done);
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC serial master testbench
// Drives directed and random command sequences with random idle and stall
// cycles on both channels, under several register settings, and checks every
// result transfer against the scoreboard model.
// ----------------------------------------------------------------------------
module tb_top;
  import twrtc_pkg::*;
  import rtc_master_tb_pkg::*;

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned NumPhases      = 5;
  localparam int unsigned RandomPerPhase = 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 kind_i;
  logic [1:0]           operation_i;
  logic [7:0]           address_i;
  logic [63:0]          write_data_i;
  logic                 io_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 chip_enable_o;
  logic                 serial_clock_o;
  logic                 data_out_o;
  logic                 data_drive_o;
  logic [7:0]           read_byte_o;
  logic                 read_valid_o;
  logic [2:0]           read_index_o;
  logic                 busy_res_o;
  logic                 done_res_o;

  rtc_waveform_scoreboard sb;
  int unsigned            send_run;
  int unsigned            recv_run;
  int unsigned            items_done;
  int unsigned            cycle_count;

  three_wire_rtc_serial_master i_dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(inout int unsigned run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run = $urandom_range(16, 48);
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic rtc_item_t random_item(kind_e kind);
    rtc_item_t item;
    item.kind       = kind;
    item.operation  = op_e'($urandom_range(0, 3));
    item.address    = 8'($urandom);
    item.write_data = {$urandom, $urandom};
    item.io_in      = 1'($urandom);
    return item;
  endfunction

  task automatic send_item(rtc_item_t item);
    int unsigned gap;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if ((item.kind == KindStart) != sb.active) begin
      items_done++;
    end
    in_valid_i   <= 1'b1;
    kind_i       <= item.kind;
    operation_i  <= item.operation;
    address_i    <= item.address;
    write_data_i <= item.write_data;
    io_in_i      <= item.io_in;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_step(item);
  endtask

  task automatic run_operation(op_e op, logic [7:0] addr, logic [63:0] data,
                               int unsigned io_mode, int unsigned noise);
    rtc_item_t item;
    item            = random_item(KindStart);
    item.operation  = op;
    item.address    = addr;
    item.write_data = data;
    send_item(item);
    while (sb.active) begin
      item = random_item(KindTick);
      if (noise > 0 && $urandom_range(0, 99) < noise) begin
        item.kind = KindStart;
      end
      case (io_mode)
        0: item.io_in = 1'b0;
        1: item.io_in = 1'b1;
        default: ;
      endcase
      send_item(item);
    end
  endtask

  task automatic write_config(logic [7:0] burst_value, logic [7:0] control_value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgBurstCommand;
    cfg_data_i  <= burst_value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(CfgBurstCommand, burst_value);
    cfg_index_i <= CfgControlAddress;
    cfg_data_i  <= control_value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(CfgControlAddress, control_value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    recv_run    = 0;
    forever begin
      stall = draw_wait(recv_run);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_step(rtc_step_t'{
        ce: chip_enable_o, sclk: serial_clock_o, dout: data_out_o, drive: data_drive_o,
        read_byte: read_byte_o, read_valid: read_valid_o, read_index: read_index_o,
        busy: busy_res_o, done: done_res_o});
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned goal;
    int unsigned pick;
    op_e         op;
    sb           = new();
    cycle_count  = 0;
    send_run     = 0;
    items_done   = 0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgBurstCommand;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    kind_i       = KindTick;
    operation_i  = OpSingleWrite;
    address_i    = '0;
    write_data_i = '0;
    io_in_i      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: write_config(8'hFF, 8'hFF);
          2: write_config(8'h00, 8'h00);
          default: write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        endcase
      end
      if (p == 0) begin
        send_item(random_item(KindTick));
        send_item(random_item(KindTick));
        run_operation(OpSingleWrite, 8'h00, '1, 2, 0);
        run_operation(OpSingleRead, 8'hFF, {$urandom, $urandom}, 1, 0);
        run_operation(OpSingleRead, 8'h00, {$urandom, $urandom}, 0, 25);
      end
      if (p == 1) begin
        run_operation(OpBurstWrite, 8'($urandom), {$urandom, $urandom}, 2, 0);
        run_operation(OpBurstRead, 8'($urandom), {$urandom, $urandom}, 2, 0);
      end
      goal = items_done + RandomPerPhase;
      while (items_done < goal) begin
        pick = $urandom_range(0, 19);
        op = (pick < 7) ? OpSingleWrite : (pick < 14) ? OpSingleRead :
             (pick < 17) ? OpBurstWrite : OpBurstRead;
        run_operation(op, 8'($urandom), {$urandom, $urandom},
                      ($urandom_range(0, 5) < 4) ? 2 : $urandom_range(0, 1), 4);
        repeat ($urandom_range(0, 2)) send_item(random_item(KindTick));
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.expected_steps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/twrtc_pkg.sv
rtl/three_wire_rtc_serial_master.sv
rtl/twrtc_checker.sv
dv/rtc_master_tb_pkg.sv
dv/tb_top.sv
